// ===== rtl/nrwr_pkg.sv =====
package nrwr_pkg;

    localparam int AccDepth   = 64;
    localparam int RejDepth   = 64;
    localparam int CoordBits  = 24;
    localparam int AccIdxBits = $clog2(AccDepth);
    localparam int RejIdxBits = $clog2(RejDepth);
    localparam int AccCntBits = $clog2(AccDepth + 1);
    localparam int RejCntBits = $clog2(RejDepth + 1);
    localparam int IdBits     = 32;
    localparam int SlotBits   = 16;
    localparam int RadBits    = 23;
    localparam int DiffBits   = CoordBits + 1;
    localparam int SqBits     = 2 * DiffBits;
    localparam int SumBits    = SqBits + 1;
    localparam int DistBits   = 49;
    localparam int RejWidth   = 2 * CoordBits + SlotBits;
    localparam int QDepth     = 2;

    typedef enum logic [2:0] {
        CMD_ADD_ACC  = 3'd0,
        CMD_ADD_REJ  = 3'd1,
        CMD_CLEAR    = 3'd2,
        CMD_FIND_ID  = 3'd3,
        CMD_FIND_NEAR = 3'd4
    } t_cmd;

    // classified work item handed from front to back
    typedef struct packed {
        logic [2:0]                 cmd;
        logic                       full;
        logic [IdBits-1:0]          identity;
        logic signed [CoordBits-1:0] qx;
        logic signed [CoordBits-1:0] qz;
        logic [RadBits-1:0]         radius;
        logic [AccCntBits-1:0]      acc_cnt;
        logic [RejCntBits-1:0]      rej_cnt;
    } t_job;

endpackage

// ===== rtl/nrwr_ram.sv =====
module nrwr_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/nrwr_front.sv =====
module nrwr_front import nrwr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_command,
    input  logic [IdBits-1:0]     i_identity,
    input  logic signed [CoordBits-1:0] i_pos_x,
    input  logic signed [CoordBits-1:0] i_pos_z,
    input  logic [SlotBits-1:0]   i_slot,
    input  logic [RadBits-1:0]    i_radius,
    output logic                  o_acc_we,
    output logic [AccIdxBits-1:0] o_acc_waddr,
    output logic [IdBits-1:0]     o_acc_wdata,
    output logic                  o_rej_we,
    output logic [RejIdxBits-1:0] o_rej_waddr,
    output logic [RejWidth-1:0]   o_rej_wdata,
    output logic                  o_job_valid,
    output t_job                  o_job,
    input  logic                  i_job_pop,
    input  logic                  i_scan_busy
);
    logic [AccCntBits-1:0] r_acc_cnt, n_acc_cnt;
    logic [RejCntBits-1:0] r_rej_cnt, n_rej_cnt;
    t_job                  r_q [QDepth];
    logic                  r_wp, r_rp;
    logic [1:0]            r_fill;
    logic                  w_take, w_acc_full, w_rej_full;
    t_job                  w_job;

    // hold a clear until no older job can still read the tables
    assign o_stall    = (r_fill == 2'(QDepth)) ||
        (i_command == CMD_CLEAR && (r_fill != 2'd0 || i_scan_busy));
    assign w_take     = i_valid && !o_stall;
    assign w_acc_full = (r_acc_cnt >= AccCntBits'(AccDepth));
    assign w_rej_full = (r_rej_cnt >= RejCntBits'(RejDepth));

    // classify the beat, update counts and append to tables
    always_comb begin
        n_acc_cnt = r_acc_cnt;
        n_rej_cnt = r_rej_cnt;
        o_acc_we  = 1'b0;
        o_rej_we  = 1'b0;
        w_job.full = 1'b0;
        if (w_take) begin
            case (i_command)
                CMD_ADD_ACC: begin
                    w_job.full = w_acc_full;
                    if (!w_acc_full) begin
                        o_acc_we  = 1'b1;
                        n_acc_cnt = r_acc_cnt + 1'b1;
                    end
                end
                CMD_ADD_REJ: begin
                    w_job.full = w_rej_full;
                    if (!w_rej_full) begin
                        o_rej_we  = 1'b1;
                        n_rej_cnt = r_rej_cnt + 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    n_acc_cnt = '0;
                    n_rej_cnt = '0;
                end
                default: ;
            endcase
        end
        w_job.cmd      = i_command;
        w_job.identity = i_identity;
        w_job.qx       = i_pos_x;
        w_job.qz       = i_pos_z;
        w_job.radius   = i_radius;
        w_job.acc_cnt  = r_acc_cnt;
        w_job.rej_cnt  = r_rej_cnt;
    end

    assign o_acc_waddr = r_acc_cnt[AccIdxBits-1:0];
    assign o_acc_wdata = i_identity;
    assign o_rej_waddr = r_rej_cnt[RejIdxBits-1:0];
    assign o_rej_wdata = {i_pos_x, i_pos_z, i_slot};

    // hold jobs in a short queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_cnt <= '0;
            r_rej_cnt <= '0;
            r_wp      <= 1'b0;
            r_rp      <= 1'b0;
            r_fill    <= '0;
        end else begin
            r_acc_cnt <= n_acc_cnt;
            r_rej_cnt <= n_rej_cnt;
            if (w_take) r_wp <= !r_wp;
            if (i_job_pop) r_rp <= !r_rp;
            r_fill <= r_fill + {1'b0, w_take} - {1'b0, i_job_pop};
        end
        if (w_take) r_q[r_wp] <= w_job;
    end

    assign o_job_valid = (r_fill != 2'd0);
    assign o_job       = r_q[r_rp];
endmodule

// ===== rtl/nrwr_back.sv =====
module nrwr_back import nrwr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  t_job                  i_job,
    output logic                  o_job_pop,
    output logic                  o_scan_busy,
    output logic [AccIdxBits-1:0] o_acc_raddr,
    input  logic [IdBits-1:0]     i_acc_rdata,
    output logic [RejIdxBits-1:0] o_rej_raddr,
    input  logic [RejWidth-1:0]   i_rej_rdata,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_status,
    output logic                  o_found,
    output logic [5:0]            o_entry_index,
    output logic [SlotBits-1:0]   o_match_slot,
    output logic [DistBits-1:0]   o_match_distance
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_SQ   = 5'b00100,
        S_CMP  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                r_state;
    t_job                  r_job;
    logic [RejCntBits-1:0] r_idx;
    logic [RejCntBits-1:0] r_cur;
    logic                  r_have;
    logic [SumBits-1:0]    r_best;
    logic [SlotBits-1:0]   r_bslot;
    logic [5:0]            r_bidx;
    logic [SqBits-1:0]     r_sqx, r_sqz;
    logic [SlotBits-1:0]   r_cslot;
    logic [RejCntBits-1:0] r_cidx;
    logic                  r_ovalid;
    logic                  r_ostatus, r_ofound;
    logic [5:0]            r_oidx;
    logic [SlotBits-1:0]   r_oslot;
    logic [DistBits-1:0]   r_odist;

    logic signed [CoordBits-1:0] w_ex, w_ez;
    logic signed [DiffBits-1:0]  w_dx, w_dz;
    logic [DiffBits-1:0]         w_mx, w_mz;
    logic [SumBits-1:0]          w_d;
    logic                        w_near, w_out_free, w_is_near;
    logic [RejCntBits-1:0]       w_cnt;

    // take a new job only once the held result beat leaves
    assign w_out_free = !r_ovalid || !i_stall;
    assign o_job_pop  = (r_state == S_IDLE) && i_job_valid && w_out_free;
    assign o_scan_busy = (r_state == S_SCAN) || (r_state == S_SQ) || (r_state == S_CMP);
    assign w_is_near  = (r_job.cmd == CMD_FIND_NEAR);
    assign w_cnt      = w_is_near ? r_job.rej_cnt : RejCntBits'(r_job.acc_cnt);
    assign o_acc_raddr = r_idx[AccIdxBits-1:0];
    assign o_rej_raddr = r_idx[RejIdxBits-1:0];

    // absolute differences of the entry read last cycle
    assign w_ex = i_rej_rdata[RejWidth-1 -: CoordBits];
    assign w_ez = i_rej_rdata[SlotBits +: CoordBits];
    assign w_dx = DiffBits'(w_ex) - DiffBits'(r_job.qx);
    assign w_dz = DiffBits'(w_ez) - DiffBits'(r_job.qz);
    assign w_mx = w_dx[DiffBits-1] ? DiffBits'(-w_dx) : DiffBits'(w_dx);
    assign w_mz = w_dz[DiffBits-1] ? DiffBits'(-w_dz) : DiffBits'(w_dz);
    assign w_d  = SumBits'(r_sqx) + SumBits'(r_sqz);
    assign w_near = (w_d < r_best) ||
        (r_have && w_d == r_best && r_cslot < r_bslot);

    // run one job: for a lookup scan a table an entry at a time, then post the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_job_pop) begin
                        r_job     <= i_job;
                        r_idx     <= '0;
                        r_have    <= 1'b0;
                        r_ofound  <= 1'b0;
                        r_oidx    <= '0;
                        r_oslot   <= '0;
                        r_odist   <= '0;
                        r_ostatus <= i_job.full;
                        r_best    <= SumBits'(i_job.radius) * SumBits'(i_job.radius);
                        if (i_job.cmd == CMD_FIND_ID || i_job.cmd == CMD_FIND_NEAR)
                            r_state <= S_SCAN;
                        else
                            r_state <= S_OUT;
                    end
                end
                S_SCAN: begin
                    // issue read of entry r_idx
                    if (r_idx >= w_cnt) begin
                        if (w_is_near && r_have) begin
                            r_ofound <= 1'b1;
                            r_oidx   <= r_bidx;
                            r_oslot  <= r_bslot;
                            r_odist  <= r_best[DistBits-1:0];
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_cur   <= r_idx;
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (w_is_near) begin
                        r_sqx   <= SqBits'(w_mx) * SqBits'(w_mx);
                        r_sqz   <= SqBits'(w_mz) * SqBits'(w_mz);
                        r_cslot <= i_rej_rdata[SlotBits-1:0];
                        r_cidx  <= r_cur;
                        r_state <= S_CMP;
                    end else if (i_acc_rdata == r_job.identity) begin
                        r_ofound <= 1'b1;
                        r_oidx   <= 6'(r_cur);
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_CMP: begin
                    if (w_near) begin
                        r_best  <= w_d;
                        r_have  <= 1'b1;
                        r_bidx  <= 6'(r_cidx);
                        r_bslot <= r_cslot;
                    end
                    r_state <= S_SCAN;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_ostatus;
    assign o_found          = r_ofound;
    assign o_entry_index    = r_oidx;
    assign o_match_slot     = r_oslot;
    assign o_match_distance = r_odist;
endmodule

// ===== rtl/nearest_record_within_radius_table.sv =====
// Channel | Direction | Handshake        | Payload
// in      | input     | i_valid/o_stall  | command identity pos_x pos_z slot radius
// out     | output    | o_valid/i_stall  | status found entry_index match_slot match_distance
// Appends, clears and unknown commands: the job goes through the queue to the back, which posts the result beat.
// Identity lookup: each stored entry scanned passes a read state and a match state (one RAM read port).
// Nearest search: each stored entry scanned passes read, square and compare states.
// The back takes a job only when the output register is free; a clear waits for older jobs.
// Synchronous active-low reset empties both tables at once via their counts.
// A two-entry job queue lets the front accept while the back scans or stalls.
module nearest_record_within_radius_table import nrwr_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [2:0]            i_command,
    input  logic [IdBits-1:0]     i_identity,
    input  logic signed [CoordBits-1:0] i_pos_x,
    input  logic signed [CoordBits-1:0] i_pos_z,
    input  logic [SlotBits-1:0]   i_slot,
    input  logic [RadBits-1:0]    i_radius,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_status,
    output logic                  o_found,
    output logic [5:0]            o_entry_index,
    output logic [SlotBits-1:0]   o_match_slot,
    output logic [DistBits-1:0]   o_match_distance
);
    logic                  w_acc_we, w_rej_we, w_job_valid, w_job_pop, w_scan_busy;
    logic [AccIdxBits-1:0] w_acc_waddr, w_acc_raddr;
    logic [RejIdxBits-1:0] w_rej_waddr, w_rej_raddr;
    logic [IdBits-1:0]     w_acc_wdata, w_acc_rdata;
    logic [RejWidth-1:0]   w_rej_wdata, w_rej_rdata;
    t_job                  w_job;

    nrwr_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_command, .i_identity,
        .i_pos_x, .i_pos_z, .i_slot, .i_radius,
        .o_acc_we(w_acc_we), .o_acc_waddr(w_acc_waddr), .o_acc_wdata(w_acc_wdata),
        .o_rej_we(w_rej_we), .o_rej_waddr(w_rej_waddr), .o_rej_wdata(w_rej_wdata),
        .o_job_valid(w_job_valid), .o_job(w_job), .i_job_pop(w_job_pop),
        .i_scan_busy(w_scan_busy)
    );

    nrwr_ram #(.Width(IdBits), .Depth(AccDepth)) u_acc_ram (
        .i_clk, .i_we(w_acc_we), .i_waddr(w_acc_waddr), .i_wdata(w_acc_wdata),
        .i_raddr(w_acc_raddr), .o_rdata(w_acc_rdata)
    );

    nrwr_ram #(.Width(RejWidth), .Depth(RejDepth)) u_rej_ram (
        .i_clk, .i_we(w_rej_we), .i_waddr(w_rej_waddr), .i_wdata(w_rej_wdata),
        .i_raddr(w_rej_raddr), .o_rdata(w_rej_rdata)
    );

    nrwr_back u_back (
        .i_clk, .i_rst_n, .i_job_valid(w_job_valid), .i_job(w_job),
        .o_job_pop(w_job_pop), .o_scan_busy(w_scan_busy),
        .o_acc_raddr(w_acc_raddr), .i_acc_rdata(w_acc_rdata),
        .o_rej_raddr(w_rej_raddr), .i_rej_rdata(w_rej_rdata),
        .o_valid, .i_stall, .o_status, .o_found, .o_entry_index,
        .o_match_slot, .o_match_distance
    );
endmodule

// ===== bench/nrwr_checker.sv =====
`timescale 1ns / 100ps

module nrwr_checker import nrwr_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_in_stall,
    input  logic [2:0]                  i_command,
    input  logic [IdBits-1:0]           i_identity,
    input  logic signed [CoordBits-1:0] i_pos_x,
    input  logic signed [CoordBits-1:0] i_pos_z,
    input  logic [SlotBits-1:0]         i_slot,
    input  logic [RadBits-1:0]          i_radius,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_status,
    input  logic                        i_found,
    input  logic [5:0]                  i_entry_index,
    input  logic [SlotBits-1:0]         i_match_slot,
    input  logic [DistBits-1:0]         i_match_distance,
    output int                          o_errors,
    output int                          o_pending
);

    typedef struct packed {
        logic                status;
        logic                found;
        logic [5:0]          index;
        logic [SlotBits-1:0] slot;
        logic [DistBits-1:0] dsq;
    } t_answer;

    logic [IdBits-1:0]           ids [AccDepth];
    logic signed [CoordBits-1:0] rxs [RejDepth];
    logic signed [CoordBits-1:0] rzs [RejDepth];
    logic [SlotBits-1:0]         rslots [RejDepth];
    int                          n_ids;
    int                          n_rej;
    t_answer                     answers_due [$];

    assign o_pending = answers_due.size();

    // compute the answer for one command beat and update the table copy
    function automatic t_answer table_answer(logic [2:0] cmd, logic [IdBits-1:0] id,
                                             logic signed [CoordBits-1:0] qx,
                                             logic signed [CoordBits-1:0] qz,
                                             logic [SlotBits-1:0] slot,
                                             logic [RadBits-1:0] radius);
        t_answer     a;
        logic [63:0] best;
        logic [63:0] d;
        logic [63:0] dx;
        logic [63:0] dz;
        logic [SlotBits-1:0] best_slot;
        bit          have;
        a = '0;
        have = 0;
        best_slot = '0;
        case (cmd)
            CMD_ADD_ACC: begin
                if (n_ids >= AccDepth) a.status = 1;
                else begin
                    ids[n_ids] = id;
                    n_ids++;
                end
            end
            CMD_ADD_REJ: begin
                if (n_rej >= RejDepth) a.status = 1;
                else begin
                    rxs[n_rej] = qx;
                    rzs[n_rej] = qz;
                    rslots[n_rej] = slot;
                    n_rej++;
                end
            end
            CMD_CLEAR: begin
                n_ids = 0;
                n_rej = 0;
            end
            CMD_FIND_ID: begin
                for (int i = 0; i < n_ids; i++) begin
                    if (ids[i] == id) begin
                        a.found = 1;
                        a.index = i[5:0];
                        break;
                    end
                end
            end
            CMD_FIND_NEAR: begin
                best = 64'(radius) * 64'(radius);
                for (int i = 0; i < n_rej; i++) begin
                    dx = 64'(rxs[i]) - 64'(qx);
                    dz = 64'(rzs[i]) - 64'(qz);
                    if (dx[63]) dx = -dx;
                    if (dz[63]) dz = -dz;
                    d = dx * dx + dz * dz;
                    if (d < best || (have && d == best && rslots[i] < best_slot)) begin
                        best = d;
                        have = 1;
                        a.index = i[5:0];
                        best_slot = rslots[i];
                    end
                end
                if (have) begin
                    a.found = 1;
                    a.slot = best_slot;
                    a.dsq = best[DistBits-1:0];
                end else begin
                    a.index = '0;
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    // predict on accepted input beats, compare accepted output beats
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            n_ids <= 0;
            n_rej <= 0;
            o_errors <= 0;
            answers_due.delete();
        end else begin
            if (i_valid && !i_in_stall)
                answers_due.insert(answers_due.size(),
                                   table_answer(i_command, i_identity, i_pos_x,
                                                i_pos_z, i_slot, i_radius));
            if (i_out_valid && !i_out_stall) begin
                got = '{i_status, i_found, i_entry_index, i_match_slot, i_match_distance};
                if (answers_due.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result beat at %0t", $realtime);
                    o_errors <= o_errors + 1;
                end else begin
                    want = answers_due.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10) begin
                            $display("mismatch at %0t: exp st=%0d f=%0d i=%0d s=%0d d=%0d",
                                     $realtime, want.status, want.found, want.index,
                                     want.slot, want.dsq);
                            $display("    got st=%0d f=%0d i=%0d s=%0d d=%0d",
                                     got.status, got.found, got.index, got.slot, got.dsq);
                        end
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import nrwr_pkg::*;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_valid;
    logic                        o_stall;
    logic [2:0]                  i_command;
    logic [IdBits-1:0]           i_identity;
    logic signed [CoordBits-1:0] i_pos_x;
    logic signed [CoordBits-1:0] i_pos_z;
    logic [SlotBits-1:0]         i_slot;
    logic [RadBits-1:0]          i_radius;
    logic                        o_valid;
    logic                        i_stall;
    logic                        o_status;
    logic                        o_found;
    logic [5:0]                  o_entry_index;
    logic [SlotBits-1:0]         o_match_slot;
    logic [DistBits-1:0]         o_match_distance;
    int                          errors;
    int                          pending;
    int                          send_idle_pct;
    int                          stall_pct;
    int                          hold_off;
    int                          cycles;
    logic [IdBits-1:0]           id_pool [8];

    nearest_record_within_radius_table uut (.*);

    nrwr_checker checker_i (
        .i_clk, .i_rst_n, .i_valid, .i_in_stall(o_stall), .i_command, .i_identity,
        .i_pos_x, .i_pos_z, .i_slot, .i_radius, .i_out_valid(o_valid),
        .i_out_stall(i_stall), .i_found(o_found), .i_entry_index(o_entry_index),
        .i_match_slot(o_match_slot), .i_match_distance(o_match_distance),
        .o_errors(errors), .o_pending(pending), .i_status(o_status)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // stall the result side at random, or hold off entirely for a stretch
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // give up at a generous limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 1500000) begin
            $display("** nearest_record_within_radius_table: FAILED **");
            $finish;
        end
    end

    // offer one command beat and hold it until taken
    task automatic send_beat(logic [2:0] cmd, logic [IdBits-1:0] id,
                             logic [CoordBits-1:0] x, logic [CoordBits-1:0] z,
                             logic [SlotBits-1:0] slot, logic [RadBits-1:0] rad);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_command <= cmd;
        i_identity <= id;
        i_pos_x <= x;
        i_pos_z <= z;
        i_slot <= slot;
        i_radius <= rad;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // mostly small coordinates near the origin, sometimes the full range
    function automatic logic [CoordBits-1:0] pick_coord();
        if ($urandom_range(9) == 0) return CoordBits'($urandom);
        return CoordBits'($signed($urandom_range(4000)) - 2000);
    endfunction

    task automatic random_beat();
        int                   sel;
        logic [IdBits-1:0]    rid;
        logic [CoordBits-1:0] rx;
        logic [CoordBits-1:0] rz;
        logic [SlotBits-1:0]  rs;
        logic [RadBits-1:0]   rr;
        sel = $urandom_range(99);
        rid = $urandom;
        rx = CoordBits'($urandom);
        rz = CoordBits'($urandom);
        rs = SlotBits'($urandom);
        rr = RadBits'($urandom);
        if (sel < 25)
            send_beat(CMD_ADD_ACC, ($urandom_range(1) ? id_pool[3'($urandom_range(7))] : rid),
                      rx, rz, rs, rr);
        else if (sel < 50) begin
            if ($urandom_range(3) != 0) rs = SlotBits'($urandom_range(3));
            send_beat(CMD_ADD_REJ, rid, pick_coord(), pick_coord(), rs, rr);
        end else if (sel < 53)
            send_beat(CMD_CLEAR, rid, rx, rz, rs, rr);
        else if (sel < 70)
            send_beat(CMD_FIND_ID, ($urandom_range(2) ? id_pool[3'($urandom_range(7))] : rid),
                      rx, rz, rs, rr);
        else if (sel < 97) begin
            if ($urandom_range(5) != 0) rr = RadBits'($urandom_range(3000));
            send_beat(CMD_FIND_NEAR, rid, pick_coord(), pick_coord(), rs, rr);
        end else
            send_beat(3'($urandom_range(7, 5)), rid, rx, rz, rs, rr);
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        i_stall = 0;
        i_command = CMD_CLEAR;
        i_identity = '0;
        i_pos_x = '0;
        i_pos_z = '0;
        i_slot = '0;
        i_radius = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 0;
        cycles = 0;
        foreach (id_pool[k]) id_pool[k] = $urandom;
        id_pool[0] = '0;
        id_pool[1] = '1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: empty queries, extremes, ties, radius edge, unknown commands, full tables, clear
        send_beat(CMD_FIND_ID, '0, '0, '0, '0, '0);
        send_beat(CMD_FIND_NEAR, '0, '0, '0, '0, '1);
        send_beat(CMD_ADD_ACC, '1, '0, '0, '0, '0);
        send_beat(CMD_ADD_ACC, '0, '0, '0, '0, '0);
        send_beat(CMD_ADD_ACC, '1, '0, '0, '0, '0);
        send_beat(CMD_FIND_ID, '1, '1, '1, '1, '1);
        send_beat(CMD_FIND_ID, '0, '0, '0, '0, '0);
        send_beat(CMD_ADD_REJ, '0, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, '0);
        send_beat(CMD_ADD_REJ, '0, 24'h800000, 24'h800000, 16'h0000, '0);
        send_beat(CMD_ADD_REJ, '0, 24'd300, 24'd400, 16'd9, '0);
        send_beat(CMD_ADD_REJ, '0, 24'd300, 24'd400, 16'd4, '0);
        send_beat(CMD_ADD_REJ, '0, 24'd300, 24'd400, 16'd4, '0);
        send_beat(CMD_FIND_NEAR, '0, '0, '0, '0, 23'd500);
        send_beat(CMD_FIND_NEAR, '0, '0, '0, '0, 23'd501);
        send_beat(CMD_FIND_NEAR, '0, '0, '0, '0, '0);
        send_beat(CMD_FIND_NEAR, '0, 24'h800000, 24'h800000, '0, '1);
        send_beat(CMD_FIND_NEAR, '0, 24'h7FFFFF, 24'h800000, '0, '1);
        send_beat(3'd5, '1, '1, '1, '1, '1);
        send_beat(3'd7, '1, '1, '1, '1, '1);
        for (int k = 0; k < 66; k++)
            send_beat(CMD_ADD_REJ, k, CoordBits'(k), CoordBits'(-k), k[15:0], '0);
        for (int k = 0; k < 66; k++) send_beat(CMD_ADD_ACC, k, '0, '0, '0, '0);
        send_beat(CMD_FIND_ID, 32'd63, '0, '0, '0, '0);
        send_beat(CMD_FIND_NEAR, '0, 24'd63, -24'sd63, '0, 23'd2);
        send_beat(CMD_CLEAR, '1, '1, '1, '1, '1);
        send_beat(CMD_FIND_ID, '1, '0, '0, '0, '0);

        // random phases with different idle mixes; long hold-off in the first
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  hold_off = 3000; end
                1: begin send_idle_pct = 72; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 72; end
                3: begin send_idle_pct = 20; stall_pct = 20; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            for (int k = 0; k < 170; k++) random_beat();
        end

        // drain
        i_valid <= 0;
        stall_pct = 0;
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0)
            $display("** nearest_record_within_radius_table: PASSED **");
        else
            $display("** nearest_record_within_radius_table: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/nrwr_pkg.sv
rtl/nrwr_ram.sv
rtl/nrwr_front.sv
rtl/nrwr_back.sv
rtl/nearest_record_within_radius_table.sv
bench/nrwr_checker.sv
bench/testbench.sv
